// ===== hdl/fbfl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the fixed-block free-list allocator.
package fbfl_pkg;

	localparam int unsigned MAX_BLOCKS   = 64;
	localparam int unsigned HEADER_BYTES = 8;

	localparam int unsigned IDX_W    = $clog2(MAX_BLOCKS);
	localparam int unsigned CNT_W    = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned BB_W     = 13;
	localparam int unsigned BIU_W    = 7;
	localparam int unsigned STRIDE_W = BB_W + 1;
	localparam int unsigned OFF_W    = 19;
	localparam int unsigned ACT_W    = 2;
	localparam int unsigned ST_W     = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = BB_W;

	// action codes
	localparam logic [ACT_W-1:0] ACT_INIT  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

	// status codes
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;
	localparam logic [ST_W-1:0] ST_NOT_ALLOC = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd1;

	// reset values of the configuration registers
	localparam logic [BB_W-1:0]  BB_RESET  = BB_W'(8);
	localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(64);

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [IDX_W-1:0] free_index;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [IDX_W-1:0] block_index;
		logic [OFF_W-1:0] block_offset;
		logic [CNT_W-1:0] free_count;
	} rsp_t;

	typedef struct packed {
		logic [BB_W-1:0]  block_bytes;
		logic [BIU_W-1:0] blocks_in_use;
	} cfg_t;

endpackage

// ===== hdl/fbfl_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: action and free index with valid/ready.
interface fbfl_req_if import fbfl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [IDX_W-1:0] free_index;

	modport source (output valid, action, free_index, input ready);
	modport sink   (input valid, action, free_index, output ready);
endinterface

// ===== hdl/fbfl_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel: status, block index, offset and free count with valid/ready.
interface fbfl_rsp_if import fbfl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ST_W-1:0]  status;
	logic [IDX_W-1:0] block_index;
	logic [OFF_W-1:0] block_offset;
	logic [CNT_W-1:0] free_count;

	modport source (output valid, status, block_index, block_offset, free_count,
		input ready);
	modport sink   (input valid, status, block_index, block_offset, free_count,
		output ready);
endinterface

// ===== hdl/fbfl_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: register index and data with valid/ready.
interface fbfl_cfg_if import fbfl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/fixed_block_free_list_allocator.sv =====
`timescale 1ns / 1ps
// Top level of the fixed-size block allocator with a LIFO free list.
//
//   channel | dir | beat carries                                 | accepted when
//   --------+-----+----------------------------------------------+----------------
//   req     | in  | action, free_index                           | valid && ready
//   rsp     | out | status, block_index, block_offset, free_count| valid && ready
//   cfg     | in  | index (0 block_bytes, 1 blocks_in_use), data | valid && ready
//
// Each request first lands in the input register while the link memory
// reads the entry at the current head; once the output register is free,
// the update runs on that registered link and the result is written to the
// output register. The registered read of the link memory sets this split.
// Reset restores the register defaults and an initialized 64-block pool;
// allocation marks live in flops, so no clearing pass is needed.
// A held result does not block intake: a new request is taken and then
// waits in the input register until the output register frees up.
module fixed_block_free_list_allocator import fbfl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fbfl_cfg_if.sink   cfg,
	fbfl_req_if.sink   req,
	fbfl_rsp_if.source rsp
);

	// configuration registers, taken by the core on init
	logic [BB_W-1:0]  block_bytes_q;
	logic [BIU_W-1:0] blocks_in_use_q;

	// input stage
	logic busy_s1;
	req_t req_s1;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic out_free;
	logic commit;
	cfg_t core_cfg;
	rsp_t core_rsp;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q   <= BB_RESET;
			blocks_in_use_q <= BIU_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_BLOCK_BYTES:   block_bytes_q   <= cfg.data[BB_W-1:0];
				CFG_BLOCKS_IN_USE: blocks_in_use_q <= cfg.data[BIU_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign core_cfg.block_bytes   = block_bytes_q;
	assign core_cfg.blocks_in_use = blocks_in_use_q;

	// one request in flight; the link read for it runs while it sits here
	assign req.ready = !busy_s1;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign commit    = busy_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (req.valid && !busy_s1) begin
			busy_s1 <= 1'b1;
		end else if (commit) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && !busy_s1) begin
			req_s1.action     <= req.action;
			req_s1.free_index <= req.free_index;
		end
	end

	fbfl_alloc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.req    (req_s1),
		.cfg    (core_cfg),
		.rsp    (core_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= core_rsp;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_q.status;
	assign rsp.block_index  = rsp_q.block_index;
	assign rsp.block_offset = rsp_q.block_offset;
	assign rsp.free_count   = rsp_q.free_count;

endmodule

// ===== hdl/fbfl_link_mem.sv =====
`timescale 1ns / 1ps
// Free-list link memory: one write port, one registered read port.
module fbfl_link_mem import fbfl_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [IDX_W-1:0] wdata,
	input  logic [IDX_W-1:0] raddr,
	output logic [IDX_W-1:0] rdata
);

	logic [IDX_W-1:0] mem [MAX_BLOCKS];
	logic [IDX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/fbfl_alloc_core.sv =====
`timescale 1ns / 1ps
// Allocator state and the single-pass init / alloc / free update.
module fbfl_alloc_core import fbfl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic commit,
	input  req_t req,
	input  cfg_t cfg,
	output rsp_t rsp
);

	logic [IDX_W-1:0]      head_q, head_d;
	logic [CNT_W-1:0]      wm_q, wm_d;
	logic [CNT_W-1:0]      free_q, free_d;
	logic [CNT_W-1:0]      pool_q, pool_d;
	logic [STRIDE_W-1:0]   stride_q, stride_d;
	logic [MAX_BLOCKS-1:0] mark_q, mark_d;

	logic [IDX_W-1:0]          link_rd;
	logic                      link_we;
	logic [CNT_W-1:0]          untouched;
	logic [CNT_W-1:0]          pool_sat;
	logic [IDX_W-1:0]          alloc_idx;
	logic [IDX_W+STRIDE_W-1:0] prod;

	fbfl_link_mem u_link_mem (
		.clk   (clk),
		.we    (link_we),
		.waddr (req.free_index),
		.wdata (head_q),
		.raddr (head_q),
		.rdata (link_rd)
	);

	assign untouched = pool_q - wm_q;
	assign pool_sat  = (cfg.blocks_in_use > BIU_W'(MAX_BLOCKS)) ?
		CNT_W'(MAX_BLOCKS) : CNT_W'(cfg.blocks_in_use);
	// list head while freed blocks remain, else next untouched block
	assign alloc_idx = (free_q > untouched) ? head_q : wm_q[IDX_W-1:0];
	assign prod      = (IDX_W+STRIDE_W)'(alloc_idx) * (IDX_W+STRIDE_W)'(stride_q);

	always_comb begin
		head_d   = head_q;
		wm_d     = wm_q;
		free_d   = free_q;
		pool_d   = pool_q;
		stride_d = stride_q;
		mark_d   = mark_q;
		link_we  = 1'b0;
		rsp      = '0;
		case (req.action)
			ACT_INIT: begin
				pool_d   = pool_sat;
				stride_d = STRIDE_W'({cfg.block_bytes[BB_W-1:3], 3'b000}) + STRIDE_W'(8);
				head_d   = '0;
				wm_d     = '0;
				free_d   = pool_sat;
				mark_d   = '0;
			end
			ACT_ALLOC: begin
				if (free_q == '0) begin
					rsp.status = ST_EMPTY;
				end else begin
					if (free_q > untouched) begin
						head_d = link_rd;
					end else begin
						wm_d = wm_q + CNT_W'(1);
					end
					mark_d[alloc_idx] = 1'b1;
					free_d            = free_q - CNT_W'(1);
					rsp.block_index   = alloc_idx;
					rsp.block_offset  = OFF_W'(prod) + OFF_W'(HEADER_BYTES);
				end
			end
			ACT_FREE: begin
				if (CNT_W'(req.free_index) >= pool_q) begin
					rsp.status = ST_RANGE;
				end else if (!mark_q[req.free_index]) begin
					rsp.status = ST_NOT_ALLOC;
				end else begin
					link_we                  = commit;
					head_d                   = req.free_index;
					mark_d[req.free_index]   = 1'b0;
					free_d                   = free_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
		rsp.free_count = free_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			wm_q     <= '0;
			free_q   <= CNT_W'(BIU_RESET);
			pool_q   <= CNT_W'(BIU_RESET);
			stride_q <= STRIDE_W'({BB_RESET[BB_W-1:3], 3'b000}) + STRIDE_W'(8);
			mark_q   <= '0;
		end else if (commit) begin
			head_q   <= head_d;
			wm_q     <= wm_d;
			free_q   <= free_d;
			pool_q   <= pool_d;
			stride_q <= stride_d;
			mark_q   <= mark_d;
		end
	end

endmodule
